// File: rtl/zsr_pkg.sv
// Shared types, character codes and CRC byte-update functions for the
// ZMODEM subpacket receiver. No dependencies.
package zsr_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] line_byte;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [7:0]  data_byte;
        logic [9:0]  byte_index;
        logic [1:0]  end_type;
        logic [10:0] data_length;
    } out_beat_t;

    localparam logic [1:0] REG_CRC32_MODE      = 2'd0;
    localparam logic [1:0] REG_ESCAPE_CONTROLS = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH      = 2'd2;

    localparam logic [2:0] RK_DATA    = 3'd0;
    localparam logic [2:0] RK_GOOD    = 3'd1;
    localparam logic [2:0] RK_CRCERR  = 3'd2;
    localparam logic [2:0] RK_LONG    = 3'd3;
    localparam logic [2:0] RK_BADESC  = 3'd4;
    localparam logic [2:0] RK_CANCEL  = 3'd5;
    localparam logic [2:0] RK_TIMEOUT = 3'd6;

    localparam logic       KIND_TIMEOUT = 1'b1;

    localparam logic [7:0] CH_XON     = 8'd17;
    localparam logic [7:0] CH_XON_HI  = 8'd145;
    localparam logic [7:0] CH_XOFF    = 8'd19;
    localparam logic [7:0] CH_XOFF_HI = 8'd147;
    localparam logic [7:0] CH_ZDLE    = 8'd24;
    localparam logic [7:0] CH_CAN     = 8'd24;
    localparam logic [7:0] CH_ZCRCE   = 8'h68;
    localparam logic [7:0] CH_ZCRCW   = 8'h6B;
    localparam logic [7:0] CH_ZRUB0   = 8'h6C;
    localparam logic [7:0] CH_ZRUB1   = 8'h6D;
    localparam logic [7:0] BIT6_MASK  = 8'd64;

    localparam logic [1:0]  CANCEL_LAST = 2'd3;
    localparam logic [31:0] CRC32_PRESET = 32'hFFFFFFFF;
    localparam logic [31:0] CRC32_POLY   = 32'hEDB88320;
    localparam logic [15:0] CRC16_POLY   = 16'h1021;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] d);
        logic [15:0] c;
        c = crc ^ {d, 8'h00};
        for (int i = 0; i < 8; i++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] d);
        logic [31:0] c;
        c = crc ^ {24'h000000, d};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ({1'b0, c[31:1]} ^ CRC32_POLY) : {1'b0, c[31:1]};
        end
        return c;
    endfunction

endpackage

// File: rtl/zsr_crc.sv
// Bytewise CRC-16 (XMODEM) and reflected CRC-32 update, selected by mode.
// Depends on zsr_pkg.
module zsr_crc (
    input  logic        crc32_mode,
    input  logic [31:0] crc_in,
    input  logic [7:0]  data_in,
    output logic [31:0] crc_out
);

    always_comb begin
        if (crc32_mode) begin
            crc_out = zsr_pkg::crc32_byte(crc_in, data_in);
        end else begin
            crc_out = {16'h0000, zsr_pkg::crc16_byte(crc_in[15:0], data_in)};
        end
    end

endmodule

// File: rtl/zsr_core.sv
// Configuration registers, subpacket state and per-beat decode: flow-control
// filtering, ZDLE unescaping, cancel detection, length limit and trailer check.
// Depends on zsr_pkg and zsr_crc.
module zsr_core #(
    parameter int MAX_SUBPACKET = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_wdata,
    input  logic               in_fire,
    input  zsr_pkg::in_beat_t  in_beat,
    output logic               res_valid,
    output zsr_pkg::out_beat_t res_beat
);

    localparam logic [16:0] MaxSub = 17'(MAX_SUBPACKET);

    logic        crc32_mode_reg;
    logic        escape_controls_reg;
    logic [10:0] max_length_reg;

    logic        in_trailer_reg, in_trailer_next;
    logic        escape_pending_reg, escape_pending_next;
    logic [1:0]  cancel_count_reg, cancel_count_next;
    logic [10:0] byte_count_reg, byte_count_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] trailer_bytes_reg, trailer_bytes_next;
    logic [1:0]  trailer_count_reg, trailer_count_next;
    logic [1:0]  latched_end_reg, latched_end_next;

    logic [7:0]  b;
    logic        ctrl;
    logic [7:0]  dec_byte;
    logic [31:0] crc_upd;
    logic [10:0] limit;
    logic        take_en;
    logic        finish;
    logic [2:0]  fin_kind;
    logic [1:0]  fin_end;
    logic [31:0] trailer_shift;

    assign b    = in_beat.line_byte;
    assign ctrl = (b[6:5] == 2'b00);

    always_comb begin
        if (!escape_pending_reg) begin
            dec_byte = b;
        end else if (b == zsr_pkg::CH_ZRUB0) begin
            dec_byte = 8'h7F;
        end else if (b == zsr_pkg::CH_ZRUB1) begin
            dec_byte = 8'hFF;
        end else if (b[6:5] == 2'b10) begin
            dec_byte = b ^ zsr_pkg::BIT6_MASK;
        end else begin
            dec_byte = b;
        end
    end

    zsr_crc u_crc (
        .crc32_mode (crc32_mode_reg),
        .crc_in     (running_crc_reg),
        .data_in    (dec_byte),
        .crc_out    (crc_upd)
    );

    assign limit = ({6'b000000, max_length_reg} > MaxSub) ? MaxSub[10:0] : max_length_reg;

    always_comb begin
        trailer_shift = 32'({dec_byte, 24'h000000} >> ({3'b000, 2'd3 - trailer_count_reg} << 3));
    end

    always_comb begin
        in_trailer_next     = in_trailer_reg;
        escape_pending_next = escape_pending_reg;
        cancel_count_next   = cancel_count_reg;
        byte_count_next     = byte_count_reg;
        running_crc_next    = running_crc_reg;
        trailer_bytes_next  = trailer_bytes_reg;
        trailer_count_next  = trailer_count_reg;
        latched_end_next    = latched_end_reg;
        take_en   = 1'b0;
        finish    = 1'b0;
        fin_kind  = zsr_pkg::RK_TIMEOUT;
        fin_end   = 2'd0;
        res_valid = 1'b0;
        res_beat  = '0;

        if (in_beat.kind == zsr_pkg::KIND_TIMEOUT) begin
            finish   = 1'b1;
            fin_kind = zsr_pkg::RK_TIMEOUT;
        end else if (b == zsr_pkg::CH_XON || b == zsr_pkg::CH_XON_HI
                     || b == zsr_pkg::CH_XOFF || b == zsr_pkg::CH_XOFF_HI) begin
            // drop flow control
        end else if (!escape_pending_reg) begin
            if (b == zsr_pkg::CH_ZDLE) begin
                escape_pending_next = 1'b1;
                cancel_count_next   = 2'd0;
            end else if (!(escape_controls_reg && ctrl)) begin
                take_en = 1'b1;
            end
        end else if (b == zsr_pkg::CH_CAN) begin
            if (cancel_count_reg == zsr_pkg::CANCEL_LAST) begin
                finish   = 1'b1;
                fin_kind = zsr_pkg::RK_CANCEL;
            end else begin
                cancel_count_next = cancel_count_reg + 2'd1;
            end
        end else if (b >= zsr_pkg::CH_ZCRCE && b <= zsr_pkg::CH_ZCRCW) begin
            if (in_trailer_reg) begin
                finish   = 1'b1;
                fin_kind = zsr_pkg::RK_BADESC;
            end else begin
                escape_pending_next = 1'b0;
                cancel_count_next   = 2'd0;
                running_crc_next    = crc_upd;
                latched_end_next    = b[1:0];
                in_trailer_next     = 1'b1;
                trailer_bytes_next  = 32'd0;
                trailer_count_next  = 2'd0;
            end
        end else if (b == zsr_pkg::CH_ZRUB0 || b == zsr_pkg::CH_ZRUB1) begin
            escape_pending_next = 1'b0;
            cancel_count_next   = 2'd0;
            take_en             = 1'b1;
        end else if (escape_controls_reg && ctrl) begin
            // drop escaped control, keep escape pending
        end else if (b[6:5] == 2'b10) begin
            escape_pending_next = 1'b0;
            cancel_count_next   = 2'd0;
            take_en             = 1'b1;
        end else begin
            finish   = 1'b1;
            fin_kind = zsr_pkg::RK_BADESC;
        end

        if (take_en) begin
            if (!in_trailer_reg) begin
                if (byte_count_reg >= limit) begin
                    finish   = 1'b1;
                    fin_kind = zsr_pkg::RK_LONG;
                end else begin
                    running_crc_next     = crc_upd;
                    byte_count_next      = byte_count_reg + 11'd1;
                    res_valid            = 1'b1;
                    res_beat.result_kind = zsr_pkg::RK_DATA;
                    res_beat.data_byte   = dec_byte;
                    res_beat.byte_index  = byte_count_reg[9:0];
                end
            end else if (crc32_mode_reg) begin
                trailer_bytes_next = trailer_bytes_reg | trailer_shift;
                trailer_count_next = trailer_count_reg + 2'd1;
                if (trailer_count_reg == 2'd3) begin
                    finish   = 1'b1;
                    fin_end  = latched_end_reg;
                    fin_kind = ((trailer_bytes_reg | trailer_shift) == ~running_crc_reg)
                               ? zsr_pkg::RK_GOOD : zsr_pkg::RK_CRCERR;
                end
            end else begin
                trailer_bytes_next = {16'h0000, trailer_bytes_reg[7:0], dec_byte};
                trailer_count_next = trailer_count_reg + 2'd1;
                if (trailer_count_reg == 2'd1) begin
                    finish   = 1'b1;
                    fin_end  = latched_end_reg;
                    fin_kind = ({trailer_bytes_reg[7:0], dec_byte} == running_crc_reg[15:0])
                               ? zsr_pkg::RK_GOOD : zsr_pkg::RK_CRCERR;
                end
            end
        end

        if (finish) begin
            res_valid            = 1'b1;
            res_beat             = '0;
            res_beat.result_kind = fin_kind;
            res_beat.end_type    = fin_end;
            res_beat.data_length = byte_count_reg;
            in_trailer_next      = 1'b0;
            escape_pending_next  = 1'b0;
            cancel_count_next    = 2'd0;
            byte_count_next      = 11'd0;
            running_crc_next     = crc32_mode_reg ? zsr_pkg::CRC32_PRESET : 32'd0;
            trailer_bytes_next   = 32'd0;
            trailer_count_next   = 2'd0;
            latched_end_next     = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc32_mode_reg      <= 1'b0;
            escape_controls_reg <= 1'b0;
            max_length_reg      <= 11'd1024;
        end else if (cfg_we) begin
            unique case (cfg_index)
                zsr_pkg::REG_CRC32_MODE:      crc32_mode_reg      <= cfg_wdata[0];
                zsr_pkg::REG_ESCAPE_CONTROLS: escape_controls_reg <= cfg_wdata[0];
                zsr_pkg::REG_MAX_LENGTH:      max_length_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_trailer_reg     <= 1'b0;
            escape_pending_reg <= 1'b0;
            cancel_count_reg   <= 2'd0;
            byte_count_reg     <= 11'd0;
            running_crc_reg    <= 32'd0;
            trailer_bytes_reg  <= 32'd0;
            trailer_count_reg  <= 2'd0;
            latched_end_reg    <= 2'd0;
        end else if (cfg_we && cfg_index == zsr_pkg::REG_CRC32_MODE) begin
            // abort subpacket, restart with new preset
            in_trailer_reg     <= 1'b0;
            escape_pending_reg <= 1'b0;
            cancel_count_reg   <= 2'd0;
            byte_count_reg     <= 11'd0;
            running_crc_reg    <= cfg_wdata[0] ? zsr_pkg::CRC32_PRESET : 32'd0;
            trailer_bytes_reg  <= 32'd0;
            trailer_count_reg  <= 2'd0;
            latched_end_reg    <= 2'd0;
        end else if (in_fire) begin
            in_trailer_reg     <= in_trailer_next;
            escape_pending_reg <= escape_pending_next;
            cancel_count_reg   <= cancel_count_next;
            byte_count_reg     <= byte_count_next;
            running_crc_reg    <= running_crc_next;
            trailer_bytes_reg  <= trailer_bytes_next;
            trailer_count_reg  <= trailer_count_next;
            latched_end_reg    <= latched_end_next;
        end
    end

endmodule

// File: rtl/zsr_obuf.sv
// Result register: holds one result beat for the downstream side and lets a
// new input beat in whenever the slot is free or being drained. Depends on zsr_pkg.
module zsr_obuf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic               res_valid,
    input  zsr_pkg::out_beat_t res_beat,
    output logic               up_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output zsr_pkg::out_beat_t m_data
);

    logic               valid_reg;
    zsr_pkg::out_beat_t data_reg;

    assign up_ready = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (up_ready) begin
            valid_reg <= in_fire && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_ready && in_fire && res_valid) begin
            data_reg <= res_beat;
        end
    end

endmodule

// File: rtl/zmodem_subpacket_receiver.sv
// ZMODEM data subpacket receiver with CRC-16 / CRC-32 trailer check.
// Depends on zsr_pkg, zsr_core and zsr_obuf.
//
// Usage:
//   s_valid/s_ready/s_data carry one line event per beat: a received byte or a
//   line timeout. m_valid/m_ready/m_data carry zero or one result per input
//   beat: a decoded data byte with its index, or a verdict that ends the
//   subpacket (good end, crc error, too long, bad escape, cancel, timeout).
//   cfg_we/cfg_index/cfg_wdata write crc32_mode, escape_controls and
//   max_length; write them only while no beat is in flight. Writing
//   crc32_mode aborts the current subpacket.
// Timing:
//   One input beat per cycle unless stalled; each beat is decoded, CRC-updated
//   and checked in the cycle it is accepted, and its result appears on m_* the
//   next cycle. The bytewise CRC update and trailer compare set the path.
// Reset:
//   aresetn low clears the subpacket state and the result register, and sets
//   CRC-16 mode, no control escaping and a length limit of 1024.
// Stall:
//   While a result waits on m_ready low, s_ready is low; s_ready returns in
//   the cycle the result is taken, so a steady stream loses no cycle.
module zmodem_subpacket_receiver #(
    parameter int MAX_SUBPACKET = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  zsr_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output zsr_pkg::out_beat_t m_data
);

    logic               in_fire;
    logic               res_valid;
    zsr_pkg::out_beat_t res_beat;

    assign in_fire = s_valid && s_ready;

    zsr_core #(
        .MAX_SUBPACKET (MAX_SUBPACKET)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .in_beat   (s_data),
        .res_valid (res_valid),
        .res_beat  (res_beat)
    );

    zsr_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .res_valid (res_valid),
        .res_beat  (res_beat),
        .up_ready  (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
